### rtl/core/jfdd_pkg.sv
// jfdd_pkg: shared widths, direction codes, register indexes and the
// key-state write port type of the flick direction detector.
// no dependencies
package jfdd_pkg;

  localparam int NUM_KEYS   = 20;
  localparam int ADC_W      = 10;
  localparam int KEY_W      = 5;
  localparam int CNT_W      = 5;
  localparam int THR_W      = 10;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  // common width for comparing an axis magnitude against the threshold
  localparam int CMP_W      = (ADC_W > THR_W) ? ADC_W : THR_W;
  localparam int ADC_CENTER = 1 << (ADC_W - 1);

  localparam logic [CNT_W-1:0] MAX_OUTPUTS_RESET = CNT_W'(20);
  localparam logic [THR_W-1:0] THRESHOLD_RESET   = THR_W'(409);

  typedef enum logic [DIR_W-1:0] {
    DIR_CENTER = 3'd0,
    DIR_LEFT   = 3'd1,
    DIR_UP     = 3'd2,
    DIR_RIGHT  = 3'd3,
    DIR_DOWN   = 3'd4,
    DIR_NONE   = 3'd5
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_OUTPUTS       = 1'b0,
    REG_DEFLECT_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    dir_t             dir;
  } mem_wr_t;

endpackage

### rtl/core/jfdd_classify.sv
// jfdd_classify: turns one pair of axis readings and the button bit into
// a direction code.
// depends on jfdd_pkg
module jfdd_classify (
  input  logic [jfdd_pkg::ADC_W-1:0] x_sample,
  input  logic [jfdd_pkg::ADC_W-1:0] y_sample,
  input  logic                       pressed,
  input  logic [jfdd_pkg::THR_W-1:0] threshold,
  output jfdd_pkg::dir_t             dir
);

  logic signed [jfdd_pkg::ADC_W:0] dx;
  logic signed [jfdd_pkg::ADC_W:0] dy;
  logic [jfdd_pkg::ADC_W:0]        dx_neg;
  logic [jfdd_pkg::ADC_W:0]        dy_neg;
  logic [jfdd_pkg::ADC_W-1:0]      ax;
  logic [jfdd_pkg::ADC_W-1:0]      ay;
  logic                            x_flick;
  logic                            y_flick;

  assign dx = $signed({1'b0, x_sample}) - $signed((jfdd_pkg::ADC_W + 1)'(jfdd_pkg::ADC_CENTER));
  assign dy = $signed({1'b0, y_sample}) - $signed((jfdd_pkg::ADC_W + 1)'(jfdd_pkg::ADC_CENTER));
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  // largest magnitude is half scale, which still fits in ADC_W bits
  assign ax = dx[jfdd_pkg::ADC_W] ? dx_neg[jfdd_pkg::ADC_W-1:0] : dx[jfdd_pkg::ADC_W-1:0];
  assign ay = dy[jfdd_pkg::ADC_W] ? dy_neg[jfdd_pkg::ADC_W-1:0] : dy[jfdd_pkg::ADC_W-1:0];

  assign x_flick = jfdd_pkg::CMP_W'(ax) > jfdd_pkg::CMP_W'(threshold);
  assign y_flick = jfdd_pkg::CMP_W'(ay) > jfdd_pkg::CMP_W'(threshold);

  always_comb begin
    priority if (pressed) begin
      dir = jfdd_pkg::DIR_CENTER;
    end else if (ax > ay) begin
      if (!x_flick) begin
        dir = jfdd_pkg::DIR_NONE;
      end else if (dx[jfdd_pkg::ADC_W]) begin
        dir = jfdd_pkg::DIR_RIGHT;
      end else begin
        dir = jfdd_pkg::DIR_LEFT;
      end
    end else begin
      // ties go to the vertical axis
      if (!y_flick) begin
        dir = jfdd_pkg::DIR_NONE;
      end else if (dy[jfdd_pkg::ADC_W]) begin
        dir = jfdd_pkg::DIR_UP;
      end else begin
        dir = jfdd_pkg::DIR_DOWN;
      end
    end
  end

endmodule

### rtl/core/jfdd_key_mem.sv
// jfdd_key_mem: per-key last direction memory, registered read, reset
// valid bits and forwarding of the most recent write.
// depends on jfdd_pkg
module jfdd_key_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [jfdd_pkg::KEY_W-1:0] rd_key,
  input  jfdd_pkg::mem_wr_t          wr,
  output jfdd_pkg::dir_t             prev
);

  jfdd_pkg::dir_t                mem [jfdd_pkg::NUM_KEYS];
  logic [jfdd_pkg::NUM_KEYS-1:0] valid;
  jfdd_pkg::dir_t                rd_data;
  logic                          rd_valid;
  logic [jfdd_pkg::KEY_W-1:0]    rd_key_q;
  logic                          fwd_valid;
  logic [jfdd_pkg::KEY_W-1:0]    fwd_key;
  jfdd_pkg::dir_t                fwd_dir;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.key] <= wr.dir;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_key];
      rd_key_q <= rd_key;
    end
    if (wr.en) begin
      fwd_key <= wr.key;
      fwd_dir <= wr.dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      rd_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.key] <= 1'b1;
        fwd_valid     <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_key];
      end
    end
  end

  // the latest write always wins over what the array returned
  always_comb begin
    priority if (fwd_valid && (fwd_key == rd_key_q)) begin
      prev = fwd_dir;
    end else if (rd_valid) begin
      prev = rd_data;
    end else begin
      prev = jfdd_pkg::DIR_NONE;
    end
  end

  a_fwd_same_edge: assert property (@(posedge clk) disable iff (rst)
    (wr.en && rd_en && (rd_key == wr.key)) |=> (prev == $past(wr.dir)))
    else $error("write not forwarded to read of same key");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (valid == '0))
    else $error("valid bits not cleared by reset");

  a_unwritten_none: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !valid[rd_key] && !(wr.en && (wr.key == rd_key)))
      |=> (prev == jfdd_pkg::DIR_NONE))
    else $error("unwritten key did not read as none");

endmodule

### rtl/core/joystick_flick_direction_detector.sv
// joystick_flick_direction_detector: top level, input stage, frame event
// budget and output register around the per-key direction memory.
// depends on jfdd_pkg, jfdd_classify, jfdd_key_mem
//
// Accepts one key sample per clock cycle while in_ready is high, and
// returns at most one word per sample, the key and its new direction,
// when that key leaves the idle position. Throughput is set by the single
// read-modify-write of the per-key memory: the sample is classified and
// its key read in the input stage, the word decided and the key written
// back in the next, with the newest write forwarded so back-to-back
// samples of one key see each other; the word is then held in the output
// register. Keys at or above the key count are dropped but their frame
// start mark still clears the per-frame event count. The user must write
// registers only while idle; the block itself does not enforce this.
module joystick_flick_direction_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [jfdd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [jfdd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [jfdd_pkg::KEY_W-1:0]      key,
  input  logic [jfdd_pkg::ADC_W-1:0]      x_sample,
  input  logic [jfdd_pkg::ADC_W-1:0]      y_sample,
  input  logic                            pressed,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jfdd_pkg::KEY_W-1:0]      event_key,
  output logic [jfdd_pkg::DIR_W-1:0]      direction
);

  logic [jfdd_pkg::CNT_W-1:0] max_outputs;
  logic [jfdd_pkg::THR_W-1:0] deflect_threshold;

  logic                       accept;
  logic                       in_range;
  jfdd_pkg::dir_t             dir_c;

  logic                       s1_valid;
  logic [jfdd_pkg::KEY_W-1:0] s1_key;
  jfdd_pkg::dir_t             s1_dir;
  logic                       s1_fs;
  logic                       s1_in_range;
  logic                       s1_adv;
  logic                       fire;

  jfdd_pkg::dir_t             prev;
  jfdd_pkg::mem_wr_t          wr;

  logic [jfdd_pkg::CNT_W-1:0] frame_event_count;
  logic [jfdd_pkg::CNT_W-1:0] cnt_base;
  logic [jfdd_pkg::CNT_W-1:0] frame_event_count_next;
  logic                       ev;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_outputs       <= jfdd_pkg::MAX_OUTPUTS_RESET;
      deflect_threshold <= jfdd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (jfdd_pkg::cfg_reg_t'(cfg_idx))
        jfdd_pkg::REG_MAX_OUTPUTS: begin
          max_outputs <= cfg_data[jfdd_pkg::CNT_W-1:0];
        end
        jfdd_pkg::REG_DEFLECT_THRESHOLD: begin
          deflect_threshold <= cfg_data[jfdd_pkg::THR_W-1:0];
        end
      endcase
    end
  end

  // input stage
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign in_range = key < jfdd_pkg::KEY_W'(jfdd_pkg::NUM_KEYS);

  jfdd_classify u_classify (
    .x_sample  (x_sample),
    .y_sample  (y_sample),
    .pressed   (pressed),
    .threshold (deflect_threshold),
    .dir       (dir_c)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key      <= key;
      s1_dir      <= dir_c;
      s1_fs       <= frame_start;
      s1_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  jfdd_key_mem u_key_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept && in_range),
    .rd_key (key),
    .wr     (wr),
    .prev   (prev)
  );

  // update stage
  assign fire     = s1_valid && s1_adv;
  assign wr.en    = fire && s1_in_range;
  assign wr.key   = s1_key;
  assign wr.dir   = s1_dir;

  assign cnt_base = s1_fs ? '0 : frame_event_count;
  assign ev       = s1_in_range && (prev == jfdd_pkg::DIR_NONE)
                    && (s1_dir != jfdd_pkg::DIR_NONE) && (cnt_base < max_outputs);
  assign frame_event_count_next = ev ? (cnt_base + jfdd_pkg::CNT_W'(1)) : cnt_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_event_count <= '0;
    end else if (fire) begin
      frame_event_count <= frame_event_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= fire && ev;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ev) begin
      event_key <= s1_key;
      direction <= s1_dir;
    end
  end

  a_no_none_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction != jfdd_pkg::DIR_NONE))
    else $error("word carries the none code");

  a_event_lands: assert property (@(posedge clk) disable iff (rst)
    (fire && ev) |=> (out_valid && (event_key == $past(s1_key))
                      && (direction == $past(s1_dir))))
    else $error("event not loaded into output register");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_fs) |=> (frame_event_count <= jfdd_pkg::CNT_W'(1)))
    else $error("frame start did not clear event count");

  a_silent_sample: assert property (@(posedge clk) disable iff (rst)
    (fire && !ev) |=> !out_valid)
    else $error("word shown for sample without event");

endmodule

### test/joystick_flick_direction_detector_test.sv
// joystick_flick_direction_detector_test: self-checking bench for the flick
// direction detector, predicting every event word from its own key state.
// depends on jfdd_pkg and joystick_flick_direction_detector
module joystick_flick_direction_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jfdd_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int KEY_MAX       = (1 << KEY_W) - 1;
  localparam int ADC_MAX       = (1 << ADC_W) - 1;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    dir_t             dir;
  } flick_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [KEY_W-1:0]      key;
  logic [ADC_W-1:0]      x_sample;
  logic [ADC_W-1:0]      y_sample;
  logic                  pressed;
  logic                  frame_start;
  logic                  out_valid;
  logic                  out_ready;
  logic [KEY_W-1:0]      event_key;
  logic [DIR_W-1:0]      direction;

  // predicted block state
  dir_t             key_dir [NUM_KEYS];
  logic [CNT_W-1:0] frame_events;
  logic [CNT_W-1:0] budget;
  logic [THR_W-1:0] threshold;
  flick_t           expected_flicks [$];

  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        gap_max = 0;
  int        burst_left = 0;
  rx_style_t rx_style = RX_ALWAYS;
  int        rx_hold = 0;
  int        rx_tick = 0;

  joystick_flick_direction_detector dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key         (key),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .pressed     (pressed),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_key   (event_key),
    .direction   (direction)
  );

  always #1 clk = ~clk;

  function automatic dir_t classify_deflection(input logic [ADC_W-1:0] xs, ys,
                                               input logic btn);
    int dx;
    int dy;
    int th;
    dx = int'(xs) - ADC_CENTER;
    dy = int'(ys) - ADC_CENTER;
    th = int'(threshold);
    if (btn) return DIR_CENTER;
    // y wins a tie
    if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
      if (dx < -th) return DIR_RIGHT;
      if (dx > th) return DIR_LEFT;
    end else begin
      if (dy < -th) return DIR_UP;
      if (dy > th) return DIR_DOWN;
    end
    return DIR_NONE;
  endfunction

  function automatic void predict_flick(input logic [KEY_W-1:0] k,
                                        input logic [ADC_W-1:0] xs, ys,
                                        input logic btn, fs);
    dir_t d;
    if (fs) frame_events = '0;
    if (k >= NUM_KEYS) return;
    d = classify_deflection(xs, ys, btn);
    if (key_dir[k] == DIR_NONE && d != DIR_NONE && frame_events < budget) begin
      frame_events++;
      expected_flicks.push_back('{key: k, dir: d});
    end
    key_dir[k] = d;
  endfunction

  function automatic logic [ADC_W-1:0] axis_value(input int off);
    if (off < -ADC_CENTER) off = -ADC_CENTER;
    if (off > ADC_CENTER - 1) off = ADC_CENTER - 1;
    return ADC_W'(off + ADC_CENTER);
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_OUTPUTS:       budget = CNT_W'(value);
      REG_DEFLECT_THRESHOLD: threshold = THR_W'(value);
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [KEY_W-1:0] k, input logic [ADC_W-1:0] xs, ys,
                             input logic btn, fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    key         <= k;
    x_sample    <= xs;
    y_sample    <= ys;
    pressed     <= btn;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    predict_flick(k, xs, ys, btn, fs);
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_flicks.size() != 0) @(posedge clk);
    // samples that give no word may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_sample();
    logic [KEY_W-1:0] k;
    logic             btn;
    int               th;
    int               m;
    int               dx;
    int               dy;
    int               t;
    int               kind;
    th   = int'(threshold);
    btn  = 1'b0;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 4) k = KEY_W'($urandom_range(NUM_KEYS, KEY_MAX));
    else k = KEY_W'($urandom_range(0, NUM_KEYS - 1));
    if (kind < 30) begin
      // resting inside the dead zone
      m  = (th > ADC_CENTER) ? ADC_CENTER : th;
      dx = int'($urandom_range(0, 2 * m)) - m;
      dy = int'($urandom_range(0, 2 * m)) - m;
    end else if (kind < 80) begin
      if (kind < 70) begin
        // flick past the threshold on one axis
        m  = $urandom_range((th >= ADC_CENTER) ? ADC_CENTER : th + 1, ADC_CENTER);
        dy = int'($urandom_range(0, 2 * m)) - m;
      end else begin
        // right at the edge of the dead zone
        m  = th + $urandom_range(0, 1);
        dy = int'($urandom_range(0, 4)) - 2;
      end
      dx = $urandom_range(0, 1) ? m : -m;
      if ($urandom_range(0, 1)) begin
        t  = dx;
        dx = dy;
        dy = t;
      end
    end else begin
      dx  = int'($urandom_range(0, ADC_MAX)) - ADC_CENTER;
      dy  = int'($urandom_range(0, ADC_MAX)) - ADC_CENTER;
      btn = (kind < 90) ? 1'b1 : 1'($urandom_range(0, 1));
    end
    send_sample(k, axis_value(dx), axis_value(dy), btn, $urandom_range(0, 11) == 0);
  endtask

  task automatic test_direction_codes();
    gap_max  = 0;
    rx_style = RX_ALWAYS;
    send_sample(0, 0, 512, 0, 1);
    send_sample(19, 1023, 512, 0, 0);
    send_sample(1, 512, 0, 0, 0);
    send_sample(2, 512, 1023, 0, 0);
    send_sample(3, 1023, 1023, 1, 0);
    send_sample(4, 512, 512, 0, 0);
    send_sample(4, 0, 0, 0, 0);
    send_sample(5, 921, 512, 0, 0);
    send_sample(5, 922, 512, 0, 0);
    send_sample(5, 922, 512, 0, 0);
    send_sample(5, 512, 512, 0, 0);
    send_sample(5, 102, 1023, 0, 0);
    send_sample(20, 0, 512, 0, 1);
    send_sample(31, 1023, 1023, 1, 1);
    send_sample(6, 103, 512, 0, 0);
    send_sample(6, 1023, 0, 0, 0);
    send_sample(16, 1023, 1023, 0, 0);
    wait_for_idle();
  endtask

  task automatic test_frame_budget();
    write_reg(REG_MAX_OUTPUTS, 1);
    send_sample(7, 512, 512, 0, 0);
    send_sample(8, 512, 512, 0, 0);
    send_sample(9, 512, 512, 0, 0);
    send_sample(7, 0, 512, 0, 1);
    // budget spent: the move is stored but gives no word
    send_sample(8, 1023, 512, 0, 0);
    send_sample(8, 512, 512, 0, 0);
    // an ignored key still opens a new frame
    send_sample(20, 512, 512, 0, 1);
    send_sample(8, 512, 0, 0, 0);
    wait_for_idle();
    write_reg(REG_MAX_OUTPUTS, 0);
    send_sample(9, 512, 1023, 0, 1);
    send_sample(9, 512, 512, 1, 0);
    send_sample(9, 512, 512, 0, 0);
    wait_for_idle();
    write_reg(REG_MAX_OUTPUTS, 20);
  endtask

  task automatic test_threshold_extremes();
    write_reg(REG_DEFLECT_THRESHOLD, 512);
    send_sample(10, 512, 512, 0, 0);
    send_sample(10, 0, 0, 0, 1);
    send_sample(10, 1023, 0, 0, 0);
    send_sample(10, 0, 1023, 1, 0);
    wait_for_idle();
    write_reg(REG_DEFLECT_THRESHOLD, 0);
    send_sample(11, 512, 512, 0, 0);
    send_sample(11, 513, 512, 0, 0);
    send_sample(12, 512, 511, 0, 0);
    send_sample(12, 512, 512, 0, 0);
    send_sample(12, 511, 513, 0, 0);
    wait_for_idle();
    write_reg(REG_DEFLECT_THRESHOLD, 409);
  endtask

  task automatic test_output_backpressure();
    gap_max  = 0;
    rx_style = RX_ALWAYS;
    rx_hold  = 300;
    for (int i = 0; i < 60; i++) begin
      if (i % 2 == 0) send_sample(KEY_W'((i / 2) % NUM_KEYS), 512, 512, 0, 0);
      else send_sample(KEY_W'((i / 2) % NUM_KEYS), 0, 512, 0, 1);
    end
    wait_for_idle();
  endtask

  task automatic test_random_traffic();
    int        budgets [6]    = '{20, 5, 1, 20, 12, 0};
    int        thresholds [6] = '{409, 200, 0, 512, 511, 0};
    int        gaps [6]       = '{0, 6, 3, 4, 8, 5};
    int        counts [6]     = '{250, 200, 150, 100, 150, 200};
    rx_style_t styles [6]     = '{RX_ALWAYS, RX_RANDOM, RX_PATTERN,
                                  RX_RANDOM, RX_PATTERN, RX_RANDOM};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MAX_OUTPUTS, (p == 5) ? $urandom_range(0, 20) : budgets[p]);
      write_reg(REG_DEFLECT_THRESHOLD, (p == 5) ? $urandom_range(0, 512) : thresholds[p]);
      gap_max  = gaps[p];
      rx_style = styles[p];
      repeat (counts[p]) send_random_sample();
      wait_for_idle();
    end
  endtask

  // receiver side: a long hold when asked, else the current stall style
  always @(negedge clk) begin
    rx_tick++;
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
        default:   out_ready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    flick_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_flicks.size() == 0) begin
        $error("unexpected word: event_key %0d direction %0d", event_key, direction);
        mismatch_count++;
      end else begin
        want = expected_flicks.pop_front();
        if (event_key !== want.key) begin
          $error("event_key: expected %0d, actual %0d", want.key, event_key);
          mismatch_count++;
        end
        if (direction !== want.dir) begin
          $error("direction: expected %0d, actual %0d", want.dir, direction);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("joystick_flick_direction_detector_test: errors");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_idx     = REG_MAX_OUTPUTS;
    cfg_data    = '0;
    in_valid    = 1'b0;
    key         = '0;
    x_sample    = '0;
    y_sample    = '0;
    pressed     = 1'b0;
    frame_start = 1'b0;
    out_ready   = 1'b0;
    foreach (key_dir[i]) key_dir[i] = DIR_NONE;
    frame_events = '0;
    budget       = MAX_OUTPUTS_RESET;
    threshold    = THRESHOLD_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_direction_codes();
    test_frame_budget();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_for_idle();

    if (mismatch_count == 0) begin
      $display("joystick_flick_direction_detector_test: clean");
    end else begin
      $display("joystick_flick_direction_detector_test: errors");
    end
    $finish;
  end

endmodule
